/* design/sgp_pkg.sv */
// Shared constants for the standoff goal pose block.
package sgp_pkg;

  // Arctangent of 2^-i as a 32-bit binary angle (2^32 = one turn)
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // 1.0 in Q1.30
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  // Inverse CORDIC gain in Q1.30
  localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
  // Half a turn as a binary angle
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  // Quarter turn, that is half of a half turn
  localparam logic signed [31:0] QUARTER_TURN = 32'sd1073741824;

endpackage

/* design/sgp_if.sv */
// Valid/ready channel interfaces for target, goal and standoff config.
interface sgp_target_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink (input valid, target_x, target_y, output ready);
endinterface

interface sgp_goal_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] goal_x;
  logic signed [31:0] goal_y;
  logic signed [31:0] quat_z;
  logic signed [31:0] quat_w;
  modport source (output valid, goal_x, goal_y, quat_z, quat_w, input ready);
  modport sink (input valid, goal_x, goal_y, quat_z, quat_w, output ready);
endinterface

interface sgp_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] standoff_distance;
  modport source (output valid, standoff_distance, input ready);
  modport sink (input valid, standoff_distance, output ready);
endinterface

/* design/standoff_goal_pose_top.sv */
// Standoff goal pose: pulled-back goal point and yaw quaternion, fully pipelined.
//
//  channel  dir  payload                              handshake
//  target   in   target_x, target_y (Q15.16)          valid/ready
//  cfg      in   standoff_distance (Q15.16, 31 bit)   valid/ready, always ready
//  goal     out  goal_x, goal_y (Q15.16), quat_z/w    valid/ready
//
//  The pipe is max(38 + FRACTION_BITS, 2*CORDIC_STAGES + 2) + 2 register stages (56 by
//  default); an accepted item is offered on goal from the last stage. The depth is set by
//  the 32-step square root plus the FRACTION_BITS+1 step divider, or by the two CORDIC
//  chains. One item enters per cycle unless the pipe holds. The whole pipe advances
//  together; when the goal item waits unaccepted the pipe holds and target.ready drops.
//  rst (synchronous) clears the valid bits and the standoff register.
module standoff_goal_pose_top #(
  parameter int CORDIC_STAGES = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  sgp_target_if.sink  target,
  sgp_cfg_if.sink     cfg,
  sgp_goal_if.source  goal
);

  localparam int N     = CORDIC_STAGES;
  localparam int FB    = FRACTION_BITS;
  localparam int QW    = FB + 1;
  localparam int PW    = 32 + QW;
  localparam int A_END = 38 + FB;
  localparam int B_END = 2 * N + 2;
  localparam int LAT   = ((A_END > B_END) ? A_END : B_END) + 2;
  localparam logic [PW-1:0] RND = PW'(1) << (FB - 1);

  typedef struct packed {
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic               zero;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [63:0]        sx;
    logic [63:0]        sy;
    logic [63:0]        rem;
    logic [31:0]        root;
    logic [32:0]        dr;
    logic [QW-1:0]      q;
    logic [PW-1:0]      px;
    logic [PW-1:0]      py;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic               xneg;
    logic               yzero;
    logic signed [34:0] vx;
    logic signed [34:0] vy;
    logic [31:0]        acc;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic signed [33:0] rz;
    logic signed [31:0] qz;
    logic signed [31:0] qw;
  } stage_t;

  function automatic logic signed [31:0] sat_q30(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'(sgp_pkg::ONE_Q30)) begin
      r = sgp_pkg::ONE_Q30;
    end else if (v < -34'(sgp_pkg::ONE_Q30)) begin
      r = -sgp_pkg::ONE_Q30;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // Standoff register
  logic [30:0] sd;
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      sd <= '0;
    end else if (cfg.valid) begin
      sd <= cfg.standoff_distance;
    end
  end

  // Pipe control: all stages move together
  logic [LAT-1:0] vld;
  logic           en;
  stage_t         st [LAT];
  stage_t         s_in;

  assign en           = !vld[LAT-1] || goal.ready;
  assign target.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], target.valid};
    end
  end

  always_comb begin
    s_in    = '0;
    s_in.tx = target.target_x;
    s_in.ty = target.target_y;
  end

  // Stage k works on stage k-1
  for (genvar k = 0; k < LAT; k++) begin : g_st
    localparam int SB = (k >= 3 && k <= 34) ? 34 - k : 0;
    localparam int DJ = (k >= 36 && k <= 36 + FB) ? k - 36 : 0;
    localparam int VI = (k >= 1 && k <= N) ? k - 1 : 0;
    localparam int RI = (k >= N + 2 && k <= 2 * N + 1) ? k - N - 2 : 0;
    stage_t prv;
    stage_t nxt;

    if (k == 0) begin : g_p0
      assign prv = s_in;
    end else begin : g_pn
      assign prv = st[k-1];
    end

    always_comb begin
      logic [63:0]        trial;
      logic [32:0]        r;
      logic [31:0]        gu;
      logic [PW-1:0]      t;
      logic signed [31:0] half;
      nxt   = prv;
      trial = '0;
      r     = '0;
      gu    = '0;
      t     = '0;
      half  = '0;
      // Track A: magnitude, scale, goal
      if (k == 0) begin
        nxt.zero  = (prv.tx == 0) && (prv.ty == 0);
        nxt.ax    = prv.tx[31] ? 32'(-prv.tx) : 32'(prv.tx);
        nxt.ay    = prv.ty[31] ? 32'(-prv.ty) : 32'(prv.ty);
        nxt.xneg  = prv.tx[31];
        nxt.yzero = (prv.ty == 0);
        nxt.vx    = prv.tx[31] ? -35'(prv.tx) : 35'(prv.tx);
        nxt.vy    = prv.tx[31] ? -35'(prv.ty) : 35'(prv.ty);
        nxt.acc   = prv.tx[31] ? sgp_pkg::HALF_TURN : 32'd0;
      end
      if (k == 1) begin
        nxt.sx = 64'(prv.ax) * 64'(prv.ax);
        nxt.sy = 64'(prv.ay) * 64'(prv.ay);
      end
      if (k == 2) begin
        nxt.rem  = prv.sx + prv.sy;
        nxt.root = '0;
      end
      // one square-root bit per stage
      if (k >= 3 && k <= 34) begin
        trial = (64'(prv.root) << (SB + 1)) + (64'd1 << (2 * SB));
        if (prv.rem >= trial) begin
          nxt.rem  = prv.rem - trial;
          nxt.root = prv.root | (32'd1 << SB);
        end
      end
      if (k == 35) begin
        nxt.dr = (prv.root > 32'(sd)) ? 33'(prv.root - 32'(sd)) : 33'd0;
        nxt.q  = '0;
      end
      // one quotient bit per stage
      if (k >= 36 && k <= 36 + FB) begin
        r = (DJ == 0) ? prv.dr : (prv.dr << 1);
        if (r >= 33'(prv.root)) begin
          r             = r - 33'(prv.root);
          nxt.q[FB-DJ]  = 1'b1;
        end
        nxt.dr = r;
      end
      if (k == 37 + FB) begin
        nxt.px = PW'(prv.ax) * PW'(prv.q);
        nxt.py = PW'(prv.ay) * PW'(prv.q);
      end
      if (k == 38 + FB) begin
        t      = prv.px + RND;
        gu     = 32'(t >> FB);
        nxt.gx = prv.tx[31] ? -$signed(gu) : $signed(gu);
        t      = prv.py + RND;
        gu     = 32'(t >> FB);
        nxt.gy = prv.ty[31] ? -$signed(gu) : $signed(gu);
      end
      // Track B: vectoring CORDIC for yaw
      if (k >= 1 && k <= N) begin
        if (!prv.vy[34]) begin
          nxt.vx  = prv.vx + (prv.vy >>> VI);
          nxt.vy  = prv.vy - (prv.vx >>> VI);
          nxt.acc = prv.acc + sgp_pkg::ATAN_TAB[VI];
        end else begin
          nxt.vx  = prv.vx - (prv.vy >>> VI);
          nxt.vy  = prv.vy + (prv.vx >>> VI);
          nxt.acc = prv.acc - sgp_pkg::ATAN_TAB[VI];
        end
      end
      // half yaw, rotation start
      if (k == N + 1) begin
        if (prv.yzero) begin
          half = prv.xneg ? sgp_pkg::QUARTER_TURN : 32'sd0;
        end else if (prv.acc == sgp_pkg::HALF_TURN) begin
          half = sgp_pkg::QUARTER_TURN;
        end else begin
          half = $signed(prv.acc) >>> 1;
        end
        nxt.rz = 34'(half);
        nxt.rx = sgp_pkg::INV_GAIN;
        nxt.ry = '0;
      end
      // rotation CORDIC
      if (k >= N + 2 && k <= 2 * N + 1) begin
        if (!prv.rz[33]) begin
          nxt.rx = prv.rx - (prv.ry >>> RI);
          nxt.ry = prv.ry + (prv.rx >>> RI);
          nxt.rz = prv.rz - 34'(sgp_pkg::ATAN_TAB[RI]);
        end else begin
          nxt.rx = prv.rx + (prv.ry >>> RI);
          nxt.ry = prv.ry - (prv.rx >>> RI);
          nxt.rz = prv.rz + 34'(sgp_pkg::ATAN_TAB[RI]);
        end
      end
      if (k == 2 * N + 2) begin
        nxt.qz = sat_q30(prv.ry);
        nxt.qw = sat_q30(prv.rx);
      end
      // zero target override, output register
      if (k == LAT - 1 && prv.zero) begin
        nxt.gx = '0;
        nxt.gy = '0;
        nxt.qz = '0;
        nxt.qw = sgp_pkg::ONE_Q30;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k] <= nxt;
      end
    end
  end

  assign goal.valid  = vld[LAT-1];
  assign goal.goal_x = st[LAT-1].gx;
  assign goal.goal_y = st[LAT-1].gy;
  assign goal.quat_z = st[LAT-1].qz;
  assign goal.quat_w = st[LAT-1].qw;

  // Checks
  a_zero_ident: assert property (@(posedge clk) disable iff (rst)
    goal.valid && st[LAT-1].zero |-> goal.quat_w == sgp_pkg::ONE_Q30 && goal.quat_z == 0)
    else $error("zero target without identity quaternion");

  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    goal.valid |-> goal.quat_z <= sgp_pkg::ONE_Q30 && goal.quat_z >= -sgp_pkg::ONE_Q30 &&
                   goal.quat_w <= sgp_pkg::ONE_Q30 && goal.quat_w >= -sgp_pkg::ONE_Q30)
    else $error("quaternion out of range");

  a_inside_standoff: assert property (@(posedge clk) disable iff (rst)
    goal.valid && st[LAT-1].root <= 32'(sd) |-> goal.goal_x == 0 && goal.goal_y == 0)
    else $error("goal not zero inside standoff");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[LAT-1] |-> target.ready)
    else $error("pipe stalled with empty output");

endmodule
